/* rtl/psc_pkg.sv */
// Shared types, constants and helper functions for the sensor compensation block.
// No dependencies; every other file refers to this package by scoped names.
package psc_pkg;

	localparam int unsigned PSC_DIV_STAGES = 32;
	localparam int unsigned PSC_FRONT_STAGES = 14;
	localparam int unsigned PSC_POST_STAGES = 5;
	localparam int unsigned PSC_LATENCY = PSC_FRONT_STAGES + PSC_DIV_STAGES + PSC_POST_STAGES;

	localparam logic [2:0] REG_CAL_TEMP = 3'd0;
	localparam logic [2:0] REG_CAL_PRESS_A = 3'd1;
	localparam logic [2:0] REG_CAL_PRESS_B = 3'd2;
	localparam logic [2:0] REG_CAL_HUM_A = 3'd3;
	localparam logic [2:0] REG_CAL_HUM_B = 3'd4;
	localparam logic [2:0] REG_HAS_HUMIDITY = 3'd5;

	localparam logic [31:0] HUM_MAX_Q22 = 32'd419430400;

	typedef struct packed {
		logic [19:0] raw_temp;
		logic [19:0] raw_press;
		logic [15:0] raw_hum;
	} psc_in_t;

	typedef struct packed {
		logic signed [31:0] temperature;
		logic [31:0] pressure;
		logic [16:0] humidity;
	} psc_out_t;

	typedef struct packed {
		logic [47:0] temp;
		logic [63:0] press_a;
		logic [63:0] press_b;
		logic [47:0] hum_a;
		logic [39:0] hum_b;
		logic hum_en;
	} psc_cal_t;

	typedef struct packed {
		logic zero;
		logic dbl;
		logic [31:0] temperature;
		logic [16:0] humidity;
	} psc_side_t;

	typedef struct packed {
		logic [31:0] dividend;
		logic [31:0] divisor;
		psc_side_t side;
	} psc_div_in_t;

	typedef struct packed {
		logic [31:0] quotient;
		psc_side_t side;
	} psc_div_out_t;

	function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] s);
		logic signed [31:0] xs;
		xs = $signed(x);
		return 32'(xs >>> s);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sx8(input logic [7:0] v);
		return {{24{v[7]}}, v};
	endfunction

endpackage

/* rtl/psc_front.sv */
// Front pipeline: temperature, fine temperature, pressure numerator and divisor, humidity.
// Depends on psc_pkg; feeds psc_div.
module psc_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  psc_pkg::psc_in_t item,
	input  psc_pkg::psc_cal_t cal,
	output logic out_vld,
	output psc_pkg::psc_div_in_t out_data
);

	logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, h1, h2, h3, h4, h5, h6;
	logic [13:0] vld_s;

	logic [31:0] a_s1, b_s1;
	logic [19:0] rp_s1, rp_s2, rp_s3, rp_s4, rp_s5, rp_s6, rp_s7, rp_s8;
	logic [15:0] rh_s1, rh_s2, rh_s3, rh_s4, rh_s5, rh_s6;
	logic [31:0] m1_s2, bb_s2;
	logic [31:0] v1t_s3, m3_s3;
	logic [31:0] fine_s4;
	logic [31:0] tq_s5, pv_s5, hx_s5;
	logic [31:0] temp_s6, qq_s6, mp5_s6, mp2_s6, mh5_s6, mh6_s6, mh3_s6;
	logic [31:0] temp_s7, v2a_s7, v2b_s7, mp3_s7, v1c_s7, upre_s7, wa_s7, wb_s7;
	logic [31:0] temp_s8, v2_s8, v1p_s8, u_s8, w1_s8;
	logic [31:0] temp_s9, mpp1_s9, pnum_s9, w2_s9, u_s9;
	logic [31:0] temp_s10, dv_s10, pm_s10, w3_s10, u_s10;
	logic [31:0] temp_s11, dv_s11, pm_s11, hx2_s11;
	logic [31:0] temp_s12, dv_s12, pm_s12, hx2_s12, ss_s12;
	logic [31:0] temp_s13, dv_s13, pm_s13, hx2_s13, ssh_s13;
	logic [31:0] xh;
	psc_pkg::psc_div_in_t res_s14;

	assign t1 = {16'd0, cal.temp[15:0]};
	assign t2 = psc_pkg::sx16(cal.temp[31:16]);
	assign t3 = psc_pkg::sx16(cal.temp[47:32]);
	assign p1 = {16'd0, cal.press_a[15:0]};
	assign p2 = psc_pkg::sx16(cal.press_a[31:16]);
	assign p3 = psc_pkg::sx16(cal.press_a[47:32]);
	assign p4 = psc_pkg::sx16(cal.press_a[63:48]);
	assign p5 = psc_pkg::sx16(cal.press_b[15:0]);
	assign p6 = psc_pkg::sx16(cal.press_b[31:16]);
	assign h1 = {24'd0, cal.hum_a[23:16]};
	assign h2 = psc_pkg::sx16(cal.hum_a[39:24]);
	assign h3 = {24'd0, cal.hum_a[47:40]};
	assign h4 = psc_pkg::sx16(cal.hum_b[15:0]);
	assign h5 = psc_pkg::sx16(cal.hum_b[31:16]);
	assign h6 = psc_pkg::sx8(cal.hum_b[39:32]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[12:0], in_vld};
		end
	end

	assign xh = hx2_s13 - psc_pkg::asr(ssh_s13, 5'd4);

	always_ff @(posedge clk) begin
		a_s1 <= {15'd0, item.raw_temp[19:3]} - (t1 << 1);
		b_s1 <= {16'd0, item.raw_temp[19:4]} - t1;
		rp_s1 <= item.raw_press;
		rh_s1 <= item.raw_hum;

		m1_s2 <= 32'(a_s1 * t2);
		bb_s2 <= 32'(b_s1 * b_s1);
		rp_s2 <= rp_s1;
		rh_s2 <= rh_s1;

		v1t_s3 <= psc_pkg::asr(m1_s2, 5'd11);
		m3_s3 <= 32'(psc_pkg::asr(bb_s2, 5'd12) * t3);
		rp_s3 <= rp_s2;
		rh_s3 <= rh_s2;

		fine_s4 <= v1t_s3 + psc_pkg::asr(m3_s3, 5'd14);
		rp_s4 <= rp_s3;
		rh_s4 <= rh_s3;

		tq_s5 <= (fine_s4 << 2) + fine_s4 + 32'd128;
		pv_s5 <= psc_pkg::asr(fine_s4, 5'd1) - 32'd64000;
		hx_s5 <= fine_s4 - 32'd76800;
		rp_s5 <= rp_s4;
		rh_s5 <= rh_s4;

		temp_s6 <= psc_pkg::asr(tq_s5, 5'd8);
		qq_s6 <= 32'(psc_pkg::asr(pv_s5, 5'd2) * psc_pkg::asr(pv_s5, 5'd2));
		mp5_s6 <= 32'(pv_s5 * p5);
		mp2_s6 <= 32'(p2 * pv_s5);
		mh5_s6 <= 32'(h5 * hx_s5);
		mh6_s6 <= 32'(hx_s5 * h6);
		mh3_s6 <= 32'(hx_s5 * h3);
		rp_s6 <= rp_s5;
		rh_s6 <= rh_s5;

		temp_s7 <= temp_s6;
		v2a_s7 <= 32'(psc_pkg::asr(qq_s6, 5'd11) * p6);
		v2b_s7 <= mp5_s6 << 1;
		mp3_s7 <= 32'(p3 * psc_pkg::asr(qq_s6, 5'd13));
		v1c_s7 <= psc_pkg::asr(mp2_s6, 5'd1);
		upre_s7 <= ({16'd0, rh_s6} << 14) - (h4 << 20) - mh5_s6 + 32'd16384;
		wa_s7 <= psc_pkg::asr(mh6_s6, 5'd10);
		wb_s7 <= psc_pkg::asr(mh3_s6, 5'd11) + 32'd32768;
		rp_s7 <= rp_s6;

		temp_s8 <= temp_s7;
		v2_s8 <= psc_pkg::asr(v2a_s7 + v2b_s7, 5'd2) + (p4 << 16);
		v1p_s8 <= psc_pkg::asr(psc_pkg::asr(mp3_s7, 5'd3) + v1c_s7, 5'd18);
		u_s8 <= psc_pkg::asr(upre_s7, 5'd15);
		w1_s8 <= 32'(wa_s7 * wb_s7);
		rp_s8 <= rp_s7;

		temp_s9 <= temp_s8;
		mpp1_s9 <= 32'((32'd32768 + v1p_s8) * p1);
		pnum_s9 <= (32'd1048576 - {12'd0, rp_s8}) - psc_pkg::asr(v2_s8, 5'd12);
		w2_s9 <= psc_pkg::asr(w1_s8, 5'd10) + 32'd2097152;
		u_s9 <= u_s8;

		temp_s10 <= temp_s9;
		dv_s10 <= psc_pkg::asr(mpp1_s9, 5'd15);
		pm_s10 <= 32'(pnum_s9 * 32'd3125);
		w3_s10 <= 32'(w2_s9 * h2) + 32'd8192;
		u_s10 <= u_s9;

		temp_s11 <= temp_s10;
		dv_s11 <= dv_s10;
		pm_s11 <= pm_s10;
		hx2_s11 <= 32'(u_s10 * psc_pkg::asr(w3_s10, 5'd14));

		temp_s12 <= temp_s11;
		dv_s12 <= dv_s11;
		pm_s12 <= pm_s11;
		hx2_s12 <= hx2_s11;
		ss_s12 <= 32'(psc_pkg::asr(hx2_s11, 5'd15) * psc_pkg::asr(hx2_s11, 5'd15));

		temp_s13 <= temp_s12;
		dv_s13 <= dv_s12;
		pm_s13 <= pm_s12;
		hx2_s13 <= hx2_s12;
		ssh_s13 <= 32'(psc_pkg::asr(ss_s12, 5'd7) * h1);

		res_s14.divisor <= dv_s13;
		res_s14.dividend <= pm_s13[31] ? pm_s13 : (pm_s13 << 1);
		res_s14.side.zero <= (dv_s13 == 32'd0);
		res_s14.side.dbl <= pm_s13[31];
		res_s14.side.temperature <= temp_s13;
		if (!cal.hum_en || xh[31]) begin
			res_s14.side.humidity <= 17'd0;
		end else if (xh > psc_pkg::HUM_MAX_Q22) begin
			res_s14.side.humidity <= psc_pkg::HUM_MAX_Q22[28:12];
		end else begin
			res_s14.side.humidity <= xh[28:12];
		end
	end

	assign out_vld = vld_s[13];
	assign out_data = res_s14;

endmodule

/* rtl/psc_div.sv */
// Pipelined unsigned 32-by-32 restoring divider, one quotient bit per stage.
// Depends on psc_pkg; carries the item's sideband alongside the quotient.
module psc_div (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  psc_pkg::psc_div_in_t in_data,
	output logic out_vld,
	output psc_pkg::psc_div_out_t out_data
);

	localparam int unsigned N = psc_pkg::PSC_DIV_STAGES;

	logic [N-1:0] vld_s;
	logic [31:0] num_s [N];
	logic [31:0] rem_s [N];
	logic [31:0] den_s [N];
	psc_pkg::psc_side_t side_s [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[N-2:0], in_vld};
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [31:0] num_in, rem_in, den_in;
		psc_pkg::psc_side_t side_in;
		logic [32:0] trial;
		logic [32:0] diff;

		if (k == 0) begin : g_first
			assign num_in = in_data.dividend;
			assign rem_in = 32'd0;
			assign den_in = in_data.divisor;
			assign side_in = in_data.side;
		end else begin : g_next
			assign num_in = num_s[k-1];
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign side_in = side_s[k-1];
		end

		assign trial = {rem_in, num_in[31]};
		assign diff = trial - {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (!diff[32]) begin
				rem_s[k] <= diff[31:0];
				num_s[k] <= {num_in[30:0], 1'b1};
			end else begin
				rem_s[k] <= trial[31:0];
				num_s[k] <= {num_in[30:0], 1'b0};
			end
			den_s[k] <= den_in;
			side_s[k] <= side_in;
		end
	end

	assign out_vld = vld_s[N-1];
	assign out_data.quotient = num_s[N-1];
	assign out_data.side = side_s[N-1];

endmodule

/* rtl/psc_post.sv */
// Pressure correction after the divide and assembly of the result item.
// Depends on psc_pkg; takes its input from psc_div.
module psc_post (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  psc_pkg::psc_div_out_t in_data,
	input  psc_pkg::psc_cal_t cal,
	output logic out_vld,
	output psc_pkg::psc_out_t out_data
);

	logic [31:0] p7, p8, p9;
	logic [4:0] vld_s;
	logic [31:0] p_s1, p_s2, p_s3, p_s4;
	psc_pkg::psc_side_t side_s1, side_s2, side_s3, side_s4;
	logic [31:0] ma_s2, mb_s2, r1m_s3, r2_s3, sum_s4;
	psc_pkg::psc_out_t res_s5;

	assign p7 = psc_pkg::sx16(cal.press_b[47:32]);
	assign p8 = psc_pkg::sx16(cal.press_b[63:48]);
	assign p9 = psc_pkg::sx16(cal.hum_a[15:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[3:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		p_s1 <= in_data.side.dbl ? (in_data.quotient << 1) : in_data.quotient;
		side_s1 <= in_data.side;

		ma_s2 <= 32'((p_s1 >> 3) * (p_s1 >> 3));
		mb_s2 <= 32'((p_s1 >> 2) * p8);
		p_s2 <= p_s1;
		side_s2 <= side_s1;

		r1m_s3 <= 32'(p9 * (ma_s2 >> 13));
		r2_s3 <= psc_pkg::asr(mb_s2, 5'd13);
		p_s3 <= p_s2;
		side_s3 <= side_s2;

		sum_s4 <= psc_pkg::asr(r1m_s3, 5'd12) + r2_s3 + p7;
		p_s4 <= p_s3;
		side_s4 <= side_s3;

		res_s5.temperature <= side_s4.temperature;
		res_s5.humidity <= side_s4.humidity;
		res_s5.pressure <= side_s4.zero ? 32'd0 : p_s4 + psc_pkg::asr(sum_s4, 5'd4);
	end

	assign out_vld = vld_s[4];
	assign out_data = res_s5;

endmodule

/* rtl/pth_sensor_compensation.sv */
// Top level of the pressure, temperature and humidity compensation block.
// Depends on psc_pkg, psc_front, psc_div and psc_post; holds the calibration registers.
//
// Each item passes from start to done through 14 arithmetic stages, a 32-stage restoring
// divider for pressure, and 5 correction stages. A new item may start in every cycle, busy
// stays low, and done pulses for one cycle with the result, which the receiver must take
// then since it cannot stall the block. Calibration registers sit at byte address 8*i on
// the 64-bit bus; the user must write them only while no item is in flight (not enforced).
module pth_sensor_compensation (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  psc_pkg::psc_in_t item,
	output logic done,
	output psc_pkg::psc_out_t result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [5:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);

	psc_pkg::psc_cal_t cal_q;
	logic [2:0] reg_idx;
	logic wr_en;
	logic front_vld, div_vld;
	psc_pkg::psc_div_in_t front_data;
	psc_pkg::psc_div_out_t div_data;

	assign pready = 1'b1;
	assign busy = 1'b0;
	assign reg_idx = paddr[5:3];
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				psc_pkg::REG_CAL_TEMP: cal_q.temp <= pwdata[47:0];
				psc_pkg::REG_CAL_PRESS_A: cal_q.press_a <= pwdata;
				psc_pkg::REG_CAL_PRESS_B: cal_q.press_b <= pwdata;
				psc_pkg::REG_CAL_HUM_A: cal_q.hum_a <= pwdata[47:0];
				psc_pkg::REG_CAL_HUM_B: cal_q.hum_b <= pwdata[39:0];
				psc_pkg::REG_HAS_HUMIDITY: cal_q.hum_en <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			psc_pkg::REG_CAL_TEMP: prdata = {16'd0, cal_q.temp};
			psc_pkg::REG_CAL_PRESS_A: prdata = cal_q.press_a;
			psc_pkg::REG_CAL_PRESS_B: prdata = cal_q.press_b;
			psc_pkg::REG_CAL_HUM_A: prdata = {16'd0, cal_q.hum_a};
			psc_pkg::REG_CAL_HUM_B: prdata = {24'd0, cal_q.hum_b};
			psc_pkg::REG_HAS_HUMIDITY: prdata = {63'd0, cal_q.hum_en};
			default: prdata = 64'd0;
		endcase
	end

	psc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(start && !busy),
		.item(item),
		.cal(cal_q),
		.out_vld(front_vld),
		.out_data(front_data)
	);

	psc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(front_vld),
		.in_data(front_data),
		.out_vld(div_vld),
		.out_data(div_data)
	);

	psc_post u_post (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(div_vld),
		.in_data(div_data),
		.cal(cal_q),
		.out_vld(done),
		.out_data(result)
	);

endmodule

/* rtl/psc_chk.sv */
// Port-level checker for the compensation block, attached to the top level by bind.
// Depends on psc_pkg for the latency and the humidity limit.
module psc_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input psc_pkg::psc_out_t result
);

	localparam int unsigned LAT = psc_pkg::PSC_LATENCY;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("Block reported busy.");

	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("Result item without a matching start.");

	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("Started item produced no result.");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.humidity <= psc_pkg::HUM_MAX_Q22[28:12]))
		else $error("Humidity result above its clamp.");

endmodule

bind pth_sensor_compensation psc_chk u_psc_chk (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.result(result)
);

/* tb/psc_checker.sv */
`timescale 1ns / 100ps
// Checker for the compensation block: it builds its own copy of the calibration registers
// from bus writes, predicts each result from the accepted items and compares field by field.
// Depends on psc_pkg for the item and result types and the register indexes.
module psc_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  psc_pkg::psc_in_t item,
	input  logic done,
	input  psc_pkg::psc_out_t result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [5:0] paddr,
	input  logic [63:0] pwdata,
	input  logic pready,
	output int errors,
	output int pending,
	output int checked
);

	logic [47:0] cal_t;
	logic [63:0] cal_pa;
	logic [63:0] cal_pb;
	logic [47:0] cal_ha;
	logic [39:0] cal_hb;
	logic hum_on;
	psc_pkg::psc_out_t expected_q[$];

	function automatic logic [31:0] sra(input logic [31:0] x, input int s);
		return 32'($signed(x) >>> s);
	endfunction

	function automatic logic [31:0] s16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic psc_pkg::psc_out_t compensate(input psc_pkg::psc_in_t it);
		logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] h1, h2, h3, h4, h5, h6;
		logic [31:0] a, b, v1, v2, q, qq, fine, p, r1, r2, x, s, u, w;
		psc_pkg::psc_out_t r;
		t1 = {16'd0, cal_t[15:0]};
		t2 = s16(cal_t[31:16]);
		t3 = s16(cal_t[47:32]);
		p1 = {16'd0, cal_pa[15:0]};
		p2 = s16(cal_pa[31:16]);
		p3 = s16(cal_pa[47:32]);
		p4 = s16(cal_pa[63:48]);
		p5 = s16(cal_pb[15:0]);
		p6 = s16(cal_pb[31:16]);
		p7 = s16(cal_pb[47:32]);
		p8 = s16(cal_pb[63:48]);
		p9 = s16(cal_ha[15:0]);
		h1 = {24'd0, cal_ha[23:16]};
		h2 = s16(cal_ha[39:24]);
		h3 = {24'd0, cal_ha[47:40]};
		h4 = s16(cal_hb[15:0]);
		h5 = s16(cal_hb[31:16]);
		h6 = {{24{cal_hb[39]}}, cal_hb[39:32]};
		a = ({12'd0, it.raw_temp} >> 3) - (t1 << 1);
		v1 = sra(a * t2, 11);
		b = ({12'd0, it.raw_temp} >> 4) - t1;
		v2 = sra(sra(b * b, 12) * t3, 14);
		fine = v1 + v2;
		r.temperature = sra(fine * 32'd5 + 32'd128, 8);
		v1 = sra(fine, 1) - 32'd64000;
		q = sra(v1, 2);
		qq = q * q;
		v2 = sra(qq, 11) * p6;
		v2 = v2 + ((v1 * p5) << 1);
		v2 = sra(v2, 2) + (p4 << 16);
		v1 = sra(sra(p3 * sra(qq, 13), 3) + sra(p2 * v1, 1), 18);
		v1 = sra((32'd32768 + v1) * p1, 15);
		if (v1 == 0) begin
			r.pressure = 0;
		end else begin
			p = ((32'd1048576 - {12'd0, it.raw_press}) - sra(v2, 12)) * 32'd3125;
			if (!p[31]) p = (p << 1) / v1;
			else p = (p / v1) * 32'd2;
			r1 = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
			r2 = sra((p >> 2) * p8, 13);
			r.pressure = p + sra(r1 + r2 + p7, 4);
		end
		if (hum_on) begin
			x = fine - 32'd76800;
			u = sra(({16'd0, it.raw_hum} << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
			w = sra(x * h6, 10) * (sra(x * h3, 11) + 32'd32768);
			w = sra(w, 10) + 32'd2097152;
			w = sra(w * h2 + 32'd8192, 14);
			x = u * w;
			s = sra(x, 15);
			x = x - sra(sra(s * s, 7) * h1, 4);
			if (x[31]) x = 0;
			else if (x > 32'd419430400) x = 32'd419430400;
			r.humidity = 17'(x >> 12);
		end else begin
			r.humidity = 0;
		end
		return r;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		psc_pkg::psc_out_t e;
		int mis;
		if (!arst_n) begin
			cal_t <= '0;
			cal_pa <= '0;
			cal_pb <= '0;
			cal_ha <= '0;
			cal_hb <= '0;
			hum_on <= 1'b0;
			errors <= 0;
			checked <= 0;
			expected_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[5:3])
					psc_pkg::REG_CAL_TEMP: cal_t <= pwdata[47:0];
					psc_pkg::REG_CAL_PRESS_A: cal_pa <= pwdata;
					psc_pkg::REG_CAL_PRESS_B: cal_pb <= pwdata;
					psc_pkg::REG_CAL_HUM_A: cal_ha <= pwdata[47:0];
					psc_pkg::REG_CAL_HUM_B: cal_hb <= pwdata[39:0];
					psc_pkg::REG_HAS_HUMIDITY: hum_on <= pwdata[0];
					default: ;
				endcase
			end
			if (done) begin
				if (expected_q.size() == 0) begin
					$error("Result with no item outstanding: %h", result);
					errors <= errors + 1;
				end else begin
					e = expected_q.pop_front();
					mis = 0;
					checked <= checked + 1;
					if (e.temperature !== result.temperature) begin
						$error("temperature expected %0d actual %0d", e.temperature,
							result.temperature);
						mis++;
					end
					if (e.pressure !== result.pressure) begin
						$error("pressure expected %0d actual %0d", e.pressure, result.pressure);
						mis++;
					end
					if (e.humidity !== result.humidity) begin
						$error("humidity expected %0d actual %0d", e.humidity, result.humidity);
						mis++;
					end
					if (mis != 0) errors <= errors + mis;
				end
			end
			if (start && !busy) expected_q.push_back(compensate(item));
		end
	end
endmodule

/* tb/tb_pth_sensor_compensation.sv */
`timescale 1ns / 100ps
// Top of the testbench: clock, reset, calibration writes over the register bus and items.
// Depends on psc_pkg, the block pth_sensor_compensation and the checker psc_checker.
module tb_pth_sensor_compensation;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	psc_pkg::psc_in_t item;
	logic done;
	psc_pkg::psc_out_t result;
	logic psel;
	logic penable;
	logic pwrite;
	logic [5:0] paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic pready;
	int errors;
	int pending;
	int checked;
	int sent;

	pth_sensor_compensation DUT (.*);
	psc_checker u_checker (.*);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#50_000_000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (psc_pkg::PSC_LATENCY + 4) @(negedge clk);
	endtask

	// Mode 0 loads typical trimming values; other modes load all ones, extremes or random sets.
	task automatic load_cal(input int mode);
		logic [63:0] r[5];
		if (mode == 0) begin
			r[0] = 64'({16'hFC18, 16'd26435, 16'd27504});
			r[1] = {16'd2855, 16'd3024, 16'hD4C9, 16'd36477};
			r[2] = {16'hFFF9, 16'd15500, 16'hFFF9, 16'd140};
			r[3] = 64'({8'd0, 16'd360, 8'd75, 16'd6000});
			r[4] = 64'({8'd30, 16'd50, 16'd312});
		end else if (mode == 1) begin
			r[0] = '1; r[1] = '1; r[2] = '1; r[3] = '1; r[4] = '1;
		end else if (mode == 2) begin
			r[0] = 64'({16'h7FFF, 16'h8000, 16'hFFFF});
			r[1] = {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF};
			r[2] = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
			r[3] = 64'({8'hFF, 16'h8000, 8'hFF, 16'h7FFF});
			r[4] = 64'({8'h80, 16'h7FFF, 16'h8000});
		end else begin
			for (int i = 0; i < 5; i++) r[i] = {$urandom, $urandom};
		end
		write_reg(psc_pkg::REG_CAL_TEMP, r[0]);
		write_reg(psc_pkg::REG_CAL_PRESS_A, r[1]);
		write_reg(psc_pkg::REG_CAL_PRESS_B, r[2]);
		write_reg(psc_pkg::REG_CAL_HUM_A, r[3]);
		write_reg(psc_pkg::REG_CAL_HUM_B, r[4]);
		write_reg(psc_pkg::REG_HAS_HUMIDITY, 64'(mode != 2));
	endtask

	task automatic send(input psc_pkg::psc_in_t it);
		int gap;
		item <= it;
		start <= 1'b1;
		do @(negedge clk); while (busy);
		sent++;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			start <= 1'b0;
			item <= 56'({$urandom, $urandom});
			repeat (gap) @(negedge clk);
		end
	endtask

	initial begin
		psc_pkg::psc_in_t it;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sent = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		send('0);
		start <= 1'b0;
		drain();
		load_cal(0);
		send({20'd519888, 20'd415148, 16'd30000});
		send({20'hFFFFF, 20'hFFFFF, 16'hFFFF});
		send({20'd0, 20'd0, 16'd0});
		send({20'h55555, 20'hAAAAA, 16'h5555});
		send({20'hAAAAA, 20'h55555, 16'hAAAA});
		start <= 1'b0;
		drain();
		for (int m = 1; m < 3; m++) begin
			load_cal(m);
			send({20'hFFFFF, 20'd0, 16'hFFFF});
			send({20'd0, 20'hFFFFF, 16'd0});
			send({20'd400000, 20'd300000, 16'd20000});
			start <= 1'b0;
			drain();
		end
		for (int ph = 0; ph < 10; ph++) begin
			load_cal((ph % 3 == 0) ? 0 : 3);
			for (int i = 0; i < 100; i++) begin
				if ($urandom_range(0, 3) != 0)
					it = {20'($urandom_range(350000, 650000)),
						20'($urandom_range(200000, 600000)), 16'($urandom_range(15000, 50000))};
				else
					it = 56'({$urandom, $urandom});
				send(it);
			end
			start <= 1'b0;
			drain();
		end
		$display("Sent %0d items over 13 calibration sets, %0d results checked.", sent, checked);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
